[hw/rtl/rwmf_pkg.sv]
package rwmf_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_RADIUS_DEF = 3;
	localparam int CFG_W          = 11;
	localparam int RAD_W          = 2;
	localparam int IDX_W          = 2;
	localparam int CH_W           = 8;
	localparam int PIX_W          = 3 * CH_W;
	localparam int QUEUE_DEPTH    = 16;

	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(600);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(400);
	localparam logic [RAD_W-1:0] RADIUS_RST = RAD_W'(1);

	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [IDX_W-1:0] {
		REG_WIDTH  = 2'd0,
		REG_HEIGHT = 2'd1,
		REG_RADIUS = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic             emit;
		logic             interior;
		logic             last;
		logic [RAD_W-1:0] radius;
	} ctl_t;

endpackage

[hw/rtl/rwmf_in_if.sv]
interface rwmf_in_if;
	import rwmf_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] red_in;
	logic            is_padding;

	modport source (output valid, blue_in, green_in, red_in, is_padding, input ready);
	modport sink (input valid, blue_in, green_in, red_in, is_padding, output ready);
endinterface

[hw/rtl/rwmf_out_if.sv]
interface rwmf_out_if;
	import rwmf_pkg::*;

	logic            valid;
	logic            ready;
	logic [CH_W-1:0] blue_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] red_out;
	logic            last_of_frame;

	modport source (output valid, blue_out, green_out, red_out, last_of_frame, input ready);
	modport sink (input valid, blue_out, green_out, red_out, last_of_frame, output ready);
endinterface

[hw/rtl/rwmf_cfg_if.sv]
interface rwmf_cfg_if;
	import rwmf_pkg::*;

	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/rwmf_ram.sv]
module rwmf_ram #(
	parameter int W = 24,
	parameter int D = 1024
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/rwmf_front.sv]
module rwmf_front import rwmf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int WD = 2 * MAX_RADIUS + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             restart,
	input  logic [CFG_W-1:0] cfg_w,
	input  logic [CFG_W-1:0] cfg_h,
	input  logic [RAD_W-1:0] cfg_r,
	input  logic             acc,
	input  pix_t             pix,
	input  logic             pad,
	output logic             emit,
	output logic             v_s2,
	output ctl_t             ctl_s2,
	output pix_t             win [0:WD-1][0:WD-1]
);

	localparam int NL = 2 * MAX_RADIUS;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = 2 * CFG_W + 2;
	localparam int XW = ((CW > CFG_W) ? CW : CFG_W) + 2;

	logic [CFG_W-1:0] w_eff;
	logic [CFG_W-1:0] h_eff;
	logic [RAD_W-1:0] r_eff;
	logic [SW-1:0]    total;
	logic [SW-1:0]    lag;
	logic [SW-1:0]    fend;
	logic [SW-1:0]    s_q;
	logic [CW-1:0]    col_q;
	logic [CW-1:0]    pc_q;
	logic [CFG_W-1:0] pr_q;
	logic             interior;
	logic             last;
	pix_t             wpix;

	logic             v_s1;
	pix_t             pix_s1;
	logic [CW-1:0]    col_s1;
	ctl_t             ctl_s1;

	logic             wr_v_q;
	logic [CW-1:0]    wr_a_q;
	pix_t             wr_d_q [0:NL-1];
	pix_t             rd [0:NL-1];
	pix_t             ld [0:NL-1];
	pix_t             lin [0:NL-1];
	pix_t             win_q [0:WD-1][0:WD-1];

	always_comb begin
		w_eff = cfg_w;
		if (cfg_w == '0) begin
			w_eff = CFG_W'(1);
		end else if (XW'(cfg_w) > XW'(MAX_WIDTH)) begin
			w_eff = CFG_W'(MAX_WIDTH);
		end
		h_eff = (cfg_h == '0) ? CFG_W'(1) : cfg_h;
		r_eff = cfg_r;
		if (cfg_r == '0) begin
			r_eff = RAD_W'(1);
		end else if (cfg_r > RAD_W'(MAX_RADIUS)) begin
			r_eff = RAD_W'(MAX_RADIUS);
		end
	end

	assign total = SW'(w_eff) * SW'(h_eff);
	assign lag   = SW'(r_eff) * SW'(w_eff) + SW'(r_eff);
	assign fend  = total + lag;
	assign emit  = s_q >= lag;
	assign last  = (s_q + SW'(1)) == fend;
	assign interior = (XW'(pr_q) >= XW'(r_eff)) && (XW'(pr_q) + XW'(r_eff) < XW'(h_eff))
		&& (XW'(pc_q) >= XW'(r_eff)) && (XW'(pc_q) + XW'(r_eff) < XW'(w_eff));
	assign wpix  = ((s_q < total) && !pad) ? pix : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q   <= '0;
			col_q <= '0;
			pc_q  <= '0;
			pr_q  <= '0;
		end else if (restart) begin
			s_q   <= '0;
			col_q <= '0;
			pc_q  <= '0;
			pr_q  <= '0;
		end else if (acc) begin
			if (last) begin
				s_q   <= '0;
				col_q <= '0;
				pc_q  <= '0;
				pr_q  <= '0;
			end else begin
				s_q <= s_q + SW'(1);
				if (XW'(col_q) + XW'(1) == XW'(w_eff)) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + CW'(1);
				end
				if (emit) begin
					if (XW'(pc_q) + XW'(1) == XW'(w_eff)) begin
						pc_q <= '0;
						pr_q <= pr_q + CFG_W'(1);
					end else begin
						pc_q <= pc_q + CW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			wr_v_q <= 1'b0;
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			v_s1   <= acc;
			v_s2   <= v_s1 && ctl_s1.emit;
			wr_v_q <= v_s1;
			ctl_s1 <= '{emit: emit, interior: interior, last: last, radius: r_eff};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1 <= wpix;
		col_s1 <= col_q;
		wr_a_q <= col_s1;
		for (int k = 0; k < NL; k++) begin
			wr_d_q[k] <= lin[k];
		end
	end

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			ld[k] = (wr_v_q && (wr_a_q == col_s1)) ? wr_d_q[k] : rd[k];
		end
		lin[0] = pix_s1;
		for (int k = 1; k < NL; k++) begin
			lin[k] = ld[k-1];
		end
	end

	for (genvar g = 0; g < NL; g++) begin : g_line
		rwmf_ram #(.W(PIX_W), .D(MAX_WIDTH)) u_line (
			.clk   (clk),
			.we    (v_s1),
			.waddr (col_s1),
			.wdata (lin[g]),
			.re    (acc),
			.raddr (col_q),
			.rdata (rd[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WD; k++) begin
				for (int j = 0; j < WD; j++) begin
					win_q[k][j] <= '0;
				end
			end
		end else if (v_s1) begin
			win_q[0][0] <= pix_s1;
			for (int k = 1; k < WD; k++) begin
				win_q[k][0] <= ld[k-1];
			end
			for (int k = 0; k < WD; k++) begin
				for (int j = 1; j < WD; j++) begin
					win_q[k][j] <= win_q[k][j-1];
				end
			end
		end
	end

	assign win = win_q;

endmodule

[hw/rtl/rwmf_median.sv]
module rwmf_median import rwmf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int WD = 2 * MAX_RADIUS + 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_v,
	input  ctl_t in_ctl,
	input  pix_t win [0:WD-1][0:WD-1],
	output logic out_v,
	output pix_t out_pix,
	output logic out_last
);

	localparam int NV = WD * WD;
	localparam int KW = $clog2(NV) + 1;
	localparam int NS = CH_W;
	localparam int RI = $clog2(WD);

	logic            v_q   [0:NS];
	ctl_t            ctl_q [0:NS];
	pix_t            ctr_q [0:NS];
	logic [CH_W-1:0] val_q [0:NS][0:2][0:NV-1];
	logic [NV-1:0]   mt_q  [0:NS][0:2];
	logic [KW-1:0]   kk_q  [0:NS][0:2];
	logic [CH_W-1:0] res_q [0:NS][0:2];

	logic [KW-1:0]   side;
	logic [KW-1:0]   kk0;
	logic [NV-1:0]   mask0;
	logic [RI-1:0]   ri;

	always_comb begin
		side = (KW'(in_ctl.radius) << 1) + KW'(1);
		kk0  = KW'((side * side) >> 1);
		ri   = RI'(in_ctl.radius);
		for (int k = 0; k < WD; k++) begin
			for (int j = 0; j < WD; j++) begin
				mask0[k*WD+j] = (KW'(k) < side) && (KW'(j) < side);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else begin
			v_q[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		ctl_q[0] <= in_ctl;
		ctr_q[0] <= win[ri][ri];
		for (int c = 0; c < 3; c++) begin
			mt_q[0][c]  <= mask0;
			kk_q[0][c]  <= kk0;
			res_q[0][c] <= '0;
			for (int k = 0; k < WD; k++) begin
				for (int j = 0; j < WD; j++) begin
					val_q[0][c][k*WD+j] <= win[k][j][c*CH_W +: CH_W];
				end
			end
		end
	end

	for (genvar s = 1; s <= NS; s++) begin : g_stage
		localparam int B = CH_W - s;
		logic [NV-1:0] zb  [0:2];
		logic [NV-1:0] ob  [0:2];
		logic [KW-1:0] cnt [0:2];

		always_comb begin
			for (int c = 0; c < 3; c++) begin
				cnt[c] = '0;
				for (int n = 0; n < NV; n++) begin
					zb[c][n] = mt_q[s-1][c][n] & ~val_q[s-1][c][n][B];
					ob[c][n] = mt_q[s-1][c][n] & val_q[s-1][c][n][B];
					cnt[c]   = cnt[c] + KW'(zb[c][n]);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[s] <= 1'b0;
			end else begin
				v_q[s] <= v_q[s-1];
			end
		end

		always_ff @(posedge clk) begin
			ctl_q[s] <= ctl_q[s-1];
			ctr_q[s] <= ctr_q[s-1];
			val_q[s] <= val_q[s-1];
			for (int c = 0; c < 3; c++) begin
				if (kk_q[s-1][c] < cnt[c]) begin
					mt_q[s][c]  <= zb[c];
					kk_q[s][c]  <= kk_q[s-1][c];
					res_q[s][c] <= res_q[s-1][c];
				end else begin
					mt_q[s][c]  <= ob[c];
					kk_q[s][c]  <= kk_q[s-1][c] - cnt[c];
					res_q[s][c] <= res_q[s-1][c] | (CH_W'(1) << B);
				end
			end
		end
	end

	assign out_v    = v_q[NS];
	assign out_last = ctl_q[NS].last;
	assign out_pix  = ctl_q[NS].interior ? {res_q[NS][2], res_q[NS][1], res_q[NS][0]}
		: ctr_q[NS];

endmodule

[hw/rtl/rwmf_fifo.sv]
module rwmf_fifo #(
	parameter int W     = 25,
	parameter int DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] dout
);

	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]    mem_q [0:DEPTH-1];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [AW:0]     cnt_q;

	assign valid = cnt_q != '0;
	assign dout  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			end
			if (pop && valid) begin
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			end
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop && valid);
		end
	end

endmodule

[hw/rtl/rgb_window_median_filter_top.sv]
// One beat is accepted per cycle while input ready is high, that is while the queue has credit.
// A result is formed once the input beat that completes its window arrives, radius rows plus
// radius pixels after the pixel itself. The window and the median pipeline take a beat every cycle.
// Reset clears the counters, the window registers and the queue and restores the
// registers to width 600, height 400 and radius 1. The line stores are not cleared.
module rgb_window_median_filter_top import rwmf_pkg::*; #(
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	rwmf_in_if.sink     pix_in,
	rwmf_out_if.source  pix_out,
	rwmf_cfg_if.sink    cfg
);

	localparam int WD = 2 * MAX_RADIUS + 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	logic [CFG_W-1:0] width_q;
	logic [CFG_W-1:0] height_q;
	logic [RAD_W-1:0] radius_q;
	logic             restart;
	logic             acc;
	logic             emit;
	logic             v_s2;
	ctl_t             ctl_s2;
	pix_t             win [0:WD-1][0:WD-1];
	logic             med_v;
	pix_t             med_pix;
	logic             med_last;
	logic [PIX_W:0]   q_dout;
	logic             q_valid;
	logic             pop;
	logic [CNW-1:0]   credit_q;

	assign cfg.ready = 1'b1;

	always_comb begin
		restart = 1'b0;
		if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH, REG_HEIGHT, REG_RADIUS: restart = 1'b1;
				default: restart = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			radius_q <= RADIUS_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_WIDTH:  width_q  <= cfg.data;
				REG_HEIGHT: height_q <= cfg.data;
				REG_RADIUS: radius_q <= cfg.data[RAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign pix_in.ready = credit_q < CNW'(QUEUE_DEPTH);
	assign acc = pix_in.valid && pix_in.ready;
	assign pop = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CNW'(acc && emit) - CNW'(pop);
		end
	end

	rwmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_RADIUS(MAX_RADIUS)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (restart),
		.cfg_w   (width_q),
		.cfg_h   (height_q),
		.cfg_r   (radius_q),
		.acc     (acc),
		.pix     ({pix_in.red_in, pix_in.green_in, pix_in.blue_in}),
		.pad     (pix_in.is_padding),
		.emit    (emit),
		.v_s2    (v_s2),
		.ctl_s2  (ctl_s2),
		.win     (win)
	);

	rwmf_median #(.MAX_RADIUS(MAX_RADIUS)) u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_v     (v_s2),
		.in_ctl   (ctl_s2),
		.win      (win),
		.out_v    (med_v),
		.out_pix  (med_pix),
		.out_last (med_last)
	);

	rwmf_fifo #(.W(PIX_W + 1), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (med_v),
		.din    ({med_last, med_pix}),
		.pop    (pix_out.ready),
		.valid  (q_valid),
		.dout   (q_dout)
	);

	assign pix_out.valid         = q_valid;
	assign pix_out.blue_out      = q_dout[CH_W-1:0];
	assign pix_out.green_out     = q_dout[2*CH_W-1:CH_W];
	assign pix_out.red_out       = q_dout[3*CH_W-1:2*CH_W];
	assign pix_out.last_of_frame = q_dout[PIX_W];

endmodule

[hw/rtl/rwmf_checker.sv]
module rwmf_checker import rwmf_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input logic [PIX_W:0]  out_data,
	input logic            cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("configuration port not ready");

	a_credit_back: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_ready) |-> $past(out_valid && out_ready))
		else $error("input ready returned without an output beat");

endmodule

bind rgb_window_median_filter_top rwmf_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  ({pix_out.last_of_frame, pix_out.red_out, pix_out.green_out, pix_out.blue_out}),
	.cfg_ready (cfg.ready)
);
